>>> design/qflt_pkg.sv
// Shared types and constants for the quoted-field line tokenizer.
// Used by qflt_scan, qflt_fifo and quoted_field_line_tokenizer; no dependencies.
`default_nettype none

package qflt_pkg;

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_BARE,
    MODE_QUOTED,
    MODE_DONE
  } mode_e;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  localparam logic [5:0] MAX_TOKENS_RESET = 6'd20;

  // width for token count compares, covers limits up to 64 plus one
  localparam int unsigned LIMIT_W = 7;

  localparam int unsigned TDATA_W = 40;

  typedef struct packed {
    logic        kind;
    logic [4:0]  token_index;
    logic [9:0]  start_offset;
    logic [10:0] token_length;
    logic [5:0]  token_total;
    logic        overflow;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic tok;
    logic eol;
  } push_t;

endpackage

`default_nettype wire

>>> design/quoted_field_line_tokenizer.sv
// Quoted-field line tokenizer top: input register, scanner, result queue.
// A byte is held in the input register; its results are written to the queue and offered from there.
// Throughput: one byte per cycle while the queue has two free entries; a byte
// may give up to two results, which drain one per cycle while m_axis_tready is high
// through a four-entry queue, and input stalls while fewer than two entries are free.
// Reset clears line state, queue and input valid flag; max_tokens resets to 20.
`default_nettype none

module quoted_field_line_tokenizer #(
  parameter int unsigned MAX_LINE_LEN    = 1024,
  parameter int unsigned MAX_TOKEN_LIMIT = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // char_byte
  input  wire logic                          s_axis_tlast,  // line_last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // token_index[4:0], start_offset[14:5], token_length[25:15],
  // token_total[31:26], overflow[32], zero fill
  output logic [qflt_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tuser,  // kind
  output logic                               m_axis_tlast,  // last_of_run
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [5:0]                    cfg_data_i     // max_tokens
);

  logic            in_vld_q, in_vld_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic [5:0]      max_tokens_q;
  logic            room, step, accept;

  qflt_pkg::push_t push;
  qflt_pkg::res_t  tok_res, eol_res, out_res;

  always_comb begin
    step          = in_vld_q && room;
    s_axis_tready = !in_vld_q || step;
    accept        = s_axis_tvalid && s_axis_tready;
    in_vld_d      = accept || (in_vld_q && !step);
    cfg_ready_o   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      max_tokens_q <= qflt_pkg::MAX_TOKENS_RESET;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_valid_i) begin
        max_tokens_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  qflt_scan #(
    .MAX_LINE_LEN    (MAX_LINE_LEN),
    .MAX_TOKEN_LIMIT (MAX_TOKEN_LIMIT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .max_tokens_i (max_tokens_q),
    .push_o       (push),
    .tok_o        (tok_res),
    .eol_o        (eol_res)
  );

  qflt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_res),
    .eol_i   (eol_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  always_comb begin
    m_axis_tdata = {7'd0, out_res.overflow, out_res.token_total, out_res.token_length,
                    out_res.start_offset, out_res.token_index};
    m_axis_tuser = out_res.kind;
    m_axis_tlast = out_res.last_of_run;
  end

endmodule

`default_nettype wire

>>> design/qflt_scan.sv
// Per-byte scanner: line state registers and single-pass token decode.
// Depends on qflt_pkg.
`default_nettype none

module qflt_scan #(
  parameter int unsigned MAX_LINE_LEN    = 1024,
  parameter int unsigned MAX_TOKEN_LIMIT = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  input  wire logic [5:0]     max_tokens_i,
  output qflt_pkg::push_t     push_o,
  output qflt_pkg::res_t      tok_o,
  output qflt_pkg::res_t      eol_o
);

  localparam int unsigned PW = $clog2(MAX_LINE_LEN + 1);
  localparam int unsigned TW = $clog2(MAX_TOKEN_LIMIT + 1);
  localparam logic [PW-1:0] LEN_MAX   = PW'(MAX_LINE_LEN);
  localparam logic [PW-1:0] START_MAX = PW'(MAX_LINE_LEN - 1);
  localparam logic [qflt_pkg::LIMIT_W-1:0] TOK_LIMIT = qflt_pkg::LIMIT_W'(MAX_TOKEN_LIMIT);

  qflt_pkg::mode_e mode_q, mode_d, mode_m;
  logic            qdbl_q, qdbl_d, qdbl_m;
  logic [PW-1:0]   pos_q, pos_d, pos_m;
  logic [PW-1:0]   tbeg_q, tbeg_d, tbeg_m;
  logic [TW-1:0]   found_q, found_d;
  logic            ovf_q, ovf_d, ovf_m;

  logic [qflt_pkg::LIMIT_W-1:0] limit, found_x, found_inc;
  logic            at_limit, inc_at_limit;
  logic            is_gap, is_open, is_quote;
  logic [7:0]      quote_ch;
  logic            emit_a, emit_b, tok;
  logic [PW-1:0]   end_a, tok_end, len_full, start;

  always_comb begin
    limit = (qflt_pkg::LIMIT_W'(max_tokens_i) > TOK_LIMIT) ? TOK_LIMIT
                                                           : qflt_pkg::LIMIT_W'(max_tokens_i);
    found_x      = qflt_pkg::LIMIT_W'(found_q);
    found_inc    = found_x + qflt_pkg::LIMIT_W'(1);
    at_limit     = found_x >= limit;
    inc_at_limit = found_inc >= limit;
    is_gap   = (byte_i == qflt_pkg::CH_SPACE) || (byte_i == qflt_pkg::CH_TAB) ||
               (byte_i == qflt_pkg::CH_CR);
    is_quote = (byte_i == qflt_pkg::CH_SQUOTE) || (byte_i == qflt_pkg::CH_DQUOTE);
    is_open  = (mode_q == qflt_pkg::MODE_BARE) || (mode_q == qflt_pkg::MODE_QUOTED);
    quote_ch = qdbl_q ? qflt_pkg::CH_DQUOTE : qflt_pkg::CH_SQUOTE;
  end

  // next state
  always_comb begin
    mode_m = mode_q;
    qdbl_m = qdbl_q;
    pos_m  = pos_q;
    tbeg_m = tbeg_q;
    ovf_m  = ovf_q;
    emit_a = 1'b0;
    end_a  = pos_q;
    if (pos_q >= LEN_MAX) begin
      ovf_m  = 1'b1;
      emit_a = is_open;
      end_a  = LEN_MAX;
      mode_m = qflt_pkg::MODE_DONE;
    end else begin
      pos_m = pos_q + PW'(1);
      if (byte_i == qflt_pkg::CH_LF) begin
        emit_a = is_open;
        mode_m = qflt_pkg::MODE_DONE;
      end else begin
        case (mode_q)
          qflt_pkg::MODE_BETWEEN: begin
            if (at_limit) begin
              mode_m = qflt_pkg::MODE_DONE;
            end else if (is_gap) begin
              mode_m = qflt_pkg::MODE_BETWEEN;
            end else if (byte_i == qflt_pkg::CH_HASH) begin
              mode_m = qflt_pkg::MODE_DONE;
            end else if (is_quote) begin
              mode_m = qflt_pkg::MODE_QUOTED;
              qdbl_m = (byte_i == qflt_pkg::CH_DQUOTE);
              tbeg_m = pos_q + PW'(1);
            end else begin
              mode_m = qflt_pkg::MODE_BARE;
              tbeg_m = pos_q;
            end
          end
          qflt_pkg::MODE_BARE:   emit_a = is_gap;
          qflt_pkg::MODE_QUOTED: emit_a = (byte_i == quote_ch);
          default: ;
        endcase
      end
    end

    // open token closed by the line's last byte
    emit_b  = last_i && !emit_a &&
              ((mode_m == qflt_pkg::MODE_BARE) || (mode_m == qflt_pkg::MODE_QUOTED));
    tok     = emit_a || emit_b;
    tok_end = emit_a ? end_a : pos_m;

    mode_d  = mode_m;
    if (tok && (mode_m != qflt_pkg::MODE_DONE)) begin
      mode_d = inc_at_limit ? qflt_pkg::MODE_DONE : qflt_pkg::MODE_BETWEEN;
    end
    qdbl_d  = qdbl_m;
    pos_d   = pos_m;
    tbeg_d  = tbeg_m;
    ovf_d   = ovf_m;
    found_d = found_q + TW'(tok);
    if (last_i) begin
      mode_d  = qflt_pkg::MODE_BETWEEN;
      qdbl_d  = 1'b0;
      pos_d   = '0;
      tbeg_d  = '0;
      ovf_d   = 1'b0;
      found_d = '0;
    end
  end

  // outputs
  always_comb begin
    len_full = (tok_end > tbeg_m) ? (tok_end - tbeg_m) : '0;
    start    = (tbeg_m > START_MAX) ? START_MAX : tbeg_m;

    tok_o.kind         = 1'b0;
    tok_o.token_index  = 5'(found_q);
    tok_o.start_offset = 10'(start);
    tok_o.token_length = 11'(len_full);
    tok_o.token_total  = '0;
    tok_o.overflow     = 1'b0;
    tok_o.last_of_run  = 1'b0;

    eol_o.kind         = 1'b1;
    eol_o.token_index  = '0;
    eol_o.start_offset = '0;
    eol_o.token_length = '0;
    eol_o.token_total  = 6'(found_x + qflt_pkg::LIMIT_W'(tok));
    eol_o.overflow     = ovf_m;
    eol_o.last_of_run  = 1'b1;

    push_o.tok = step_i && tok;
    push_o.eol = step_i && last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= qflt_pkg::MODE_BETWEEN;
      qdbl_q  <= 1'b0;
      pos_q   <= '0;
      tbeg_q  <= '0;
      found_q <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      qdbl_q  <= qdbl_d;
      pos_q   <= pos_d;
      tbeg_q  <= tbeg_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
    end
  end

  a_done_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (mode_q == qflt_pkg::MODE_DONE)) |-> !push_o.tok)
    else $error("token emitted after line scan finished");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (pos_q == '0) && (found_q == '0) &&
                           (mode_q == qflt_pkg::MODE_BETWEEN) && !ovf_q)
    else $error("line state not cleared after line end");

  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qflt_pkg::LIMIT_W'(found_q) <= TOK_LIMIT)
    else $error("token count exceeds limit");

endmodule

`default_nettype wire

>>> design/qflt_fifo.sv
// Four-entry result queue, takes up to two results per cycle, gives one while ready_i is high.
// Depends on qflt_pkg.
`default_nettype none

module qflt_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qflt_pkg::push_t push_i,
  input  wire qflt_pkg::res_t  tok_i,
  input  wire qflt_pkg::res_t  eol_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output qflt_pkg::res_t       data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;

  qflt_pkg::res_t mem_q [DEPTH];
  logic [AW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           pop;

  always_comb begin
    valid_o = cnt_q != '0;
    room_o  = cnt_q <= CW'(DEPTH - 2);
    data_o  = mem_q[rp_q];
    pop     = valid_o && ready_i;
    wp_d    = wp_q + AW'(push_i.tok) + AW'(push_i.eol);
    rp_d    = rp_q + AW'(pop);
    cnt_d   = cnt_q + CW'(push_i.tok) + CW'(push_i.eol) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.tok) begin
      mem_q[wp_q] <= tok_i;
    end
    if (push_i.eol) begin
      mem_q[wp_q + AW'(push_i.tok)] <= eol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.tok || push_i.eol) |-> (cnt_q <= CW'(DEPTH - 2)))
    else $error("result push without room");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.tok && !push_i.eol) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("result queue count wrong after transfer");

endmodule

`default_nettype wire
